@@ design/rpc_pkg.sv @@
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types, constants and fixed-point helpers for the rational polynomial
// ground-to-image block.
// ----------------------------------------------------------------------------
package rpc_pkg;

    localparam int NUM_COEFFS = 80;
    localparam int TERMS      = 20;
    localparam int MONO_OPS   = 18;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_POINT = 1'b1;

    localparam logic [2:0] REG_LAT_OFFSET   = 3'd0;
    localparam logic [2:0] REG_LONG_OFFSET  = 3'd1;
    localparam logic [2:0] REG_LAT_SCALE_I  = 3'd2;
    localparam logic [2:0] REG_LONG_SCALE_I = 3'd3;
    localparam logic [2:0] REG_SAMP_OFFSET  = 3'd4;
    localparam logic [2:0] REG_SAMP_SCALE   = 3'd5;
    localparam logic [2:0] REG_LINE_OFFSET  = 3'd6;
    localparam logic [2:0] REG_LINE_SCALE   = 3'd7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    // Monomial build order: operands and destination per step.
    localparam logic [4:0] MONO_A [MONO_OPS] = '{
        5'd0, 5'd0, 5'd1, 5'd1, 5'd2, 5'd1, 5'd2, 5'd3, 5'd4,
        5'd1, 5'd1, 5'd1, 5'd7, 5'd2, 5'd2, 5'd7, 5'd8, 5'd3};
    localparam logic [4:0] MONO_B [MONO_OPS] = '{
        5'd0, 5'd0, 5'd2, 5'd3, 5'd3, 5'd1, 5'd2, 5'd3, 5'd3,
        5'd7, 5'd8, 5'd9, 5'd2, 5'd8, 5'd9, 5'd3, 5'd3, 5'd9};
    localparam logic [4:0] MONO_DST [MONO_OPS] = '{
        5'd2, 5'd1, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10,
        5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19};

    typedef struct packed {
        logic signed [31:0] val;
        logic               sat;
    } sat32_t;

    function automatic sat32_t sat32(input logic signed [65:0] x);
        sat32_t r;
        r.sat = 1'b0;
        if (x > 66'sd2147483647)
        begin
            r.val = 32'sh7fffffff;
            r.sat = 1'b1;
        end
        else if (x < -66'sd2147483648)
        begin
            r.val = 32'sh80000000;
            r.sat = 1'b1;
        end
        else
        begin
            r.val = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic signed [32:0] abs33(input logic signed [31:0] x);
        logic signed [32:0] r;
        r = x[31] ? -33'(x) : 33'(x);
        return r;
    endfunction

endpackage

@@ design/rpc_coeff_mem.sv @@
// ----------------------------------------------------------------------------
// rpc_coeff_mem
// Coefficient store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rpc_coeff_mem
(
    input  logic        clk,
    input  logic        we,
    input  logic [6:0]  waddr,
    input  logic [31:0] wdata,
    input  logic        re,
    input  logic [6:0]  raddr,
    output logic [31:0] rdata
);
    import rpc_pkg::*;

    logic [31:0] mem [NUM_COEFFS];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

@@ design/rpc_div.sv @@
// ----------------------------------------------------------------------------
// rpc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpc_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [64:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [64:0] quotient
);
    logic [31:0] rem_reg;
    logic [31:0] div_reg;
    logic [64:0] quo_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] shifted;
    logic [32:0] diff;
    logic        ge;

    assign shifted = {rem_reg, quo_reg[64]};
    assign diff    = shifted - {1'b0, div_reg};
    assign ge      = shifted >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                div_reg  <= divisor;
                quo_reg  <= dividend;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[31:0] : shifted[31:0];
                quo_reg <= {quo_reg[63:0], ge};
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd64)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ design/rational_polynomial_ground_to_image_top.sv @@
// ----------------------------------------------------------------------------
// rational_polynomial_ground_to_image_top
// Ground point (latitude, longitude, height) to image sample and line with
// a 20-term cubic rational polynomial model; coefficients loaded by word.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_ready   | op .. last_point
//   out     | output    | out_valid/out_ready | sample_pos .. last_out
//   cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// A load word is written to the coefficient store as it is accepted. An
// accepted point runs 18 monomial multiply/write-back steps, 80 coefficient
// reads, a term pipeline drain, a check, and per channel a multiply, the
// bit-serial divider and a finish, then sets out_valid; a zero denominator
// skips both channels. One point is in work at a time; the next word is
// accepted once its result is in the output registers. rst_n clears control
// state; the coefficient store is undefined until loaded. A result waiting on
// out_ready does not block the next word; the point after it waits in S_DONE.
// ----------------------------------------------------------------------------
module rational_polynomial_ground_to_image_top
#(
    parameter int COEFF_WIDTH = 32,
    parameter int COORD_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [6:0]                    coeff_index,
    input  logic signed [COEFF_WIDTH-1:0] coeff_value,
    input  logic signed [COORD_WIDTH-1:0] latitude,
    input  logic signed [COORD_WIDTH-1:0] longitude,
    input  logic signed [31:0]            height_norm,
    input  logic                          last_point,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [47:0]            sample_pos,
    output logic signed [47:0]            line_pos,
    output logic [1:0]                    status,
    output logic                          last_out,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_data
);
    import rpc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MONO_MUL, S_MONO_WB, S_TERM, S_DRAIN, S_CHECK,
        S_DEN_MUL, S_DIV_GO, S_DIV_WAIT, S_DEN_FIN, S_DONE
    } state_t;

    state_t state_reg;

    logic signed [31:0] lat_off_reg, long_off_reg, lat_inv_reg, long_inv_reg;
    logic signed [31:0] samp_off_reg, samp_scale_reg, line_off_reg, line_scale_reg;

    logic signed [31:0] lat_reg, long_reg;
    logic               last_reg;
    logic signed [31:0] mono_reg [TERMS];
    logic [4:0]         step_reg;
    logic               sat_reg;

    logic [6:0]         cnt_reg;
    logic [4:0]         term_reg;
    logic [1:0]         bank_reg;
    logic               v1_reg, v2_reg;
    logic [4:0]         term1_reg, term2_reg;
    logic [1:0]         bank1_reg, bank2_reg;
    logic signed [31:0] coef2_reg;
    logic signed [47:0] acc_reg [4];

    logic signed [31:0] sn_reg, sd_reg, ln_reg, ld_reg;
    logic               ch_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;

    logic               out_valid_reg;
    logic signed [47:0] samp_res_reg, line_res_reg;
    logic [1:0]         status_res_reg;
    logic signed [47:0] sample_pos_reg, line_pos_reg;
    logic [1:0]         status_reg;
    logic               last_out_reg;
    logic               out_load;

    logic               accept;
    logic               mem_we;
    logic               mem_re;
    logic [31:0]        mem_rdata;
    logic signed [31:0] coeff_clamped;

    logic               div_start;
    logic               div_done;
    logic [64:0]        div_quo;

    logic signed [65:0] mono_rnd;
    sat32_t             mono_sat;
    logic signed [47:0] term_add;
    sat32_t             sn_s, sd_s, ln_s, ld_s;

    logic signed [31:0] cur_num, cur_den, cur_scale, cur_off;
    logic               cur_neg;
    logic [48:0]        mag;
    logic signed [50:0] val;
    logic               val_ovf;
    logic signed [47:0] val_sat;

    assign accept        = in_valid && in_ready;
    assign in_ready      = (state_reg == S_IDLE);
    assign coeff_clamped = clamp32(64'(coeff_value));
    assign mem_we        = accept && (op == OP_LOAD) && (coeff_index < 7'(NUM_COEFFS));
    assign mem_re        = (state_reg == S_TERM);
    assign out_load      = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    rpc_coeff_mem u_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (coeff_index),
        .wdata (coeff_clamped),
        .re    (mem_re),
        .raddr (cnt_reg),
        .rdata (mem_rdata)
    );

    assign cur_num   = ch_reg ? ln_reg : sn_reg;
    assign cur_den   = ch_reg ? ld_reg : sd_reg;
    assign cur_scale = ch_reg ? line_scale_reg : samp_scale_reg;
    assign cur_off   = ch_reg ? line_off_reg : samp_off_reg;
    assign cur_neg   = cur_num[31] ^ cur_scale[31] ^ cur_den[31];

    assign div_start = (state_reg == S_DIV_GO);

    rpc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({prod_reg[62:0], 2'b00}),
        .divisor  (32'(abs33(cur_den))),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MONO_MUL:
            begin
                if (step_reg == 5'd0)
                begin
                    mul_a = 33'(lat_reg) - 33'(lat_off_reg);
                    mul_b = 33'(lat_inv_reg);
                end
                else if (step_reg == 5'd1)
                begin
                    mul_a = 33'(long_reg) - 33'(long_off_reg);
                    mul_b = 33'(long_inv_reg);
                end
                else
                begin
                    mul_a = 33'(mono_reg[MONO_A[step_reg]]);
                    mul_b = 33'(mono_reg[MONO_B[step_reg]]);
                end
            end
            S_TERM, S_DRAIN:
            begin
                mul_a = 33'($signed(mem_rdata));
                mul_b = 33'(mono_reg[term1_reg]);
            end
            S_DEN_MUL:
            begin
                mul_a = abs33(cur_num);
                mul_b = abs33(cur_scale);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mono_rnd = (step_reg < 5'd2) ? ((prod_reg + (66'sd1 <<< 21)) >>> 22)
                                        : ((prod_reg + (66'sd1 <<< 23)) >>> 24);
    assign mono_sat = sat32(mono_rnd);
    assign term_add = (term2_reg == 5'd0) ? 48'(coef2_reg)
                                          : 48'((prod_reg + (66'sd1 <<< 23)) >>> 24);

    assign sn_s = sat32(66'(acc_reg[0]));
    assign sd_s = sat32(66'(acc_reg[1]));
    assign ln_s = sat32(66'(acc_reg[2]));
    assign ld_s = sat32(66'(acc_reg[3]));

    assign mag     = (|div_quo[64:48]) ? {1'b1, 48'd0} : {1'b0, div_quo[47:0]};
    assign val     = (cur_neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag}))
                     + ($signed(51'(cur_off)) <<< 2);
    assign val_ovf = !((val[50:47] == 4'b0000) || (val[50:47] == 4'b1111));
    assign val_sat = val_ovf ? (val[50] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
                             : val[47:0];

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            lat_off_reg    <= '0;
            long_off_reg   <= '0;
            lat_inv_reg    <= 32'sd16777216;
            long_inv_reg   <= 32'sd16777216;
            samp_off_reg   <= '0;
            samp_scale_reg <= 32'sd16384;
            line_off_reg   <= '0;
            line_scale_reg <= 32'sd16384;
            out_valid_reg  <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            step_reg       <= '0;
            cnt_reg        <= '0;
            term_reg       <= '0;
            bank_reg       <= '0;
            ch_reg         <= 1'b0;
            sat_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LAT_OFFSET:   lat_off_reg    <= cfg_data;
                    REG_LONG_OFFSET:  long_off_reg   <= cfg_data;
                    REG_LAT_SCALE_I:  lat_inv_reg    <= cfg_data;
                    REG_LONG_SCALE_I: long_inv_reg   <= cfg_data;
                    REG_SAMP_OFFSET:  samp_off_reg   <= cfg_data;
                    REG_SAMP_SCALE:   samp_scale_reg <= cfg_data;
                    REG_LINE_OFFSET:  line_off_reg   <= cfg_data;
                    REG_LINE_SCALE:   line_scale_reg <= cfg_data;
                endcase
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            // term pipeline: read, multiply, accumulate
            v1_reg    <= (state_reg == S_TERM);
            term1_reg <= term_reg;
            bank1_reg <= bank_reg;
            v2_reg    <= v1_reg;
            term2_reg <= term1_reg;
            bank2_reg <= bank1_reg;
            coef2_reg <= mem_rdata;
            if (v2_reg)
                acc_reg[bank2_reg] <= acc_reg[bank2_reg] + term_add;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (op == OP_POINT))
                    begin
                        lat_reg     <= clamp32(64'(latitude));
                        long_reg    <= clamp32(64'(longitude));
                        last_reg    <= last_point;
                        mono_reg[0] <= '0;
                        mono_reg[3] <= height_norm;
                        step_reg    <= '0;
                        sat_reg     <= 1'b0;
                        state_reg   <= S_MONO_MUL;
                    end
                end
                S_MONO_MUL:
                begin
                    state_reg <= S_MONO_WB;
                end
                S_MONO_WB:
                begin
                    mono_reg[MONO_DST[step_reg]] <= mono_sat.val;
                    sat_reg <= sat_reg | mono_sat.sat;
                    if (step_reg == 5'(MONO_OPS - 1))
                    begin
                        cnt_reg    <= '0;
                        term_reg   <= '0;
                        bank_reg   <= '0;
                        acc_reg[0] <= '0;
                        acc_reg[1] <= '0;
                        acc_reg[2] <= '0;
                        acc_reg[3] <= '0;
                        state_reg  <= S_TERM;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 5'd1;
                        state_reg <= S_MONO_MUL;
                    end
                end
                S_TERM:
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                    if (term_reg == 5'(TERMS - 1))
                    begin
                        term_reg <= '0;
                        bank_reg <= bank_reg + 2'd1;
                    end
                    else
                    begin
                        term_reg <= term_reg + 5'd1;
                    end
                    if (cnt_reg == 7'(NUM_COEFFS - 1))
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    if (!v1_reg && !v2_reg)
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    sn_reg  <= sn_s.val;
                    sd_reg  <= sd_s.val;
                    ln_reg  <= ln_s.val;
                    ld_reg  <= ld_s.val;
                    sat_reg <= sat_reg | sn_s.sat | sd_s.sat | ln_s.sat | ld_s.sat;
                    ch_reg  <= 1'b0;
                    if ((sd_s.val == 32'sd0) || (ld_s.val == 32'sd0))
                    begin
                        samp_res_reg   <= '0;
                        line_res_reg   <= '0;
                        status_res_reg <= ST_ZERO_DEN;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_DEN_MUL;
                    end
                end
                S_DEN_MUL:
                begin
                    state_reg <= S_DIV_GO;
                end
                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                        state_reg <= S_DEN_FIN;
                end
                S_DEN_FIN:
                begin
                    if (ch_reg)
                    begin
                        line_res_reg   <= val_sat;
                        status_res_reg <= (sat_reg || val_ovf) ? ST_SAT : ST_OK;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        samp_res_reg <= val_sat;
                        sat_reg      <= sat_reg | val_ovf;
                        ch_reg       <= 1'b1;
                        state_reg    <= S_DEN_MUL;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        sample_pos_reg <= samp_res_reg;
                        line_pos_reg   <= line_res_reg;
                        status_reg     <= status_res_reg;
                        last_out_reg   <= last_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_pos = sample_pos_reg;
    assign line_pos   = line_pos_reg;
    assign status     = status_reg;
    assign last_out   = last_out_reg;

endmodule
